// File: design/ual_pkg.sv
// shared types, constants and codes of the unsorted array list
package ual_pkg;

  // list storage
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int VAL_W    = 32;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;
  localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_RESULT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    add_wr;
    logic    clear;
    logic    scan_start;
    logic    scan_step;
    logic    move_rd;
    logic    move_wr;
    logic    set_status;
    status_e status;
    logic    out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic hit;
    logic miss_done;
  } dp_stat_t;

endpackage

// File: design/ual_ctrl.sv
// controller state machine of the unsorted array list
module ual_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ual_pkg::dp_stat_t     stat_i,
  output ual_pkg::ctrl_cmd_t    cmd_o
);

  ual_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ual_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.status = ual_pkg::ST_OK;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ual_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ual_pkg::S_EXEC;
        end
      end
      ual_pkg::S_EXEC: begin
        state_d = ual_pkg::S_RESULT;
        case (stat_i.op)
          ual_pkg::OP_ADD: begin
            if (stat_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ual_pkg::ST_FULL;
            end else begin
              cmd_o.add_wr = 1'b1;
            end
          end
          ual_pkg::OP_CLEAR: begin
            cmd_o.clear = 1'b1;
          end
          ual_pkg::OP_DELETE: begin
            if (stat_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ual_pkg::ST_EMPTY;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = ual_pkg::S_SCAN;
            end
          end
          default: begin
            cmd_o.scan_start = 1'b1;
            state_d          = ual_pkg::S_SCAN;
          end
        endcase
      end
      ual_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.hit) begin
          state_d = (stat_i.op == ual_pkg::OP_DELETE) ? ual_pkg::S_MOVE_RD
                                                      : ual_pkg::S_RESULT;
        end else if (stat_i.miss_done) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ual_pkg::ST_NOT_FOUND;
          state_d          = ual_pkg::S_RESULT;
        end
      end
      ual_pkg::S_MOVE_RD: begin
        cmd_o.move_rd = 1'b1;
        state_d       = ual_pkg::S_MOVE_WR;
      end
      ual_pkg::S_MOVE_WR: begin
        cmd_o.move_wr = 1'b1;
        state_d       = ual_pkg::S_RESULT;
      end
      ual_pkg::S_RESULT: begin
        // wait until the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ual_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ual_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/ual_dp.sv
// datapath of the unsorted array list: entry memory, scan and result registers
module ual_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ual_pkg::ctrl_cmd_t             cmd_i,
  output ual_pkg::dp_stat_t              stat_o,
  input  logic [ual_pkg::CAP_W-1:0]      cap_i,
  input  logic [1:0]                     in_command_i,
  input  logic [ual_pkg::VAL_W-1:0]      in_value_i,
  output ual_pkg::status_e               out_status_o,
  output logic [ual_pkg::FOUND_W-1:0]    out_index_o,
  output logic [ual_pkg::VAL_W-1:0]      out_removed_o,
  output logic [ual_pkg::COUNT_W-1:0]    out_count_o,
  output logic [ual_pkg::CNT_W-1:0]      fill_o
);

  logic [ual_pkg::VAL_W-1:0] mem_q [ual_pkg::CAPACITY];

  logic [ual_pkg::CNT_W-1:0] fill_q, fill_d;
  logic [ual_pkg::CNT_W-1:0] scan_q, scan_d;
  logic                      rd_vld_q, rd_vld_d;
  logic [ual_pkg::IDX_W-1:0] rd_idx_q;
  logic [ual_pkg::VAL_W-1:0] rd_data_q;

  ual_pkg::op_e              op_q;
  logic [ual_pkg::VAL_W-1:0] val_q;
  ual_pkg::status_e          res_status_q;
  logic [ual_pkg::IDX_W-1:0] res_idx_q;
  logic [ual_pkg::VAL_W-1:0] res_removed_q;

  ual_pkg::status_e             out_status_q;
  logic [ual_pkg::FOUND_W-1:0]  out_index_q;
  logic [ual_pkg::VAL_W-1:0]    out_removed_q;
  logic [ual_pkg::COUNT_W-1:0]  out_count_q;

  logic [ual_pkg::CMP_W-1:0] lim;
  logic                      scan_more;
  logic                      hit;
  logic                      rd_en;
  logic [ual_pkg::IDX_W-1:0] rd_addr;
  logic [ual_pkg::IDX_W-1:0] last_idx;

  // effective capacity and status toward the controller
  always_comb begin
    if (ual_pkg::CMP_W'(cap_i) > ual_pkg::CMP_W'(ual_pkg::CAPACITY)) begin
      lim = ual_pkg::CMP_W'(ual_pkg::CAPACITY);
    end else begin
      lim = ual_pkg::CMP_W'(cap_i);
    end
  end

  assign scan_more = scan_q < fill_q;
  assign hit       = rd_vld_q && (rd_data_q == val_q);
  assign last_idx  = ual_pkg::IDX_W'(fill_q - ual_pkg::CNT_W'(1));

  assign stat_o.op        = op_q;
  assign stat_o.full      = ual_pkg::CMP_W'(fill_q) >= lim;
  assign stat_o.empty     = fill_q == '0;
  assign stat_o.hit       = hit;
  assign stat_o.miss_done = !rd_vld_q && !scan_more;

  // memory read port: scan reads walk up, the move reads the last entry
  assign rd_en   = (cmd_i.scan_step && scan_more) || cmd_i.move_rd;
  assign rd_addr = cmd_i.move_rd ? last_idx : scan_q[ual_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  // memory write port: append on add, fill the hole on delete
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr) begin
      mem_q[fill_q[ual_pkg::IDX_W-1:0]] <= val_q;
    end else if (cmd_i.move_wr) begin
      mem_q[res_idx_q] <= rd_data_q;
    end
  end

  // fill count and scan pointer
  always_comb begin
    fill_d   = fill_q;
    scan_d   = scan_q;
    rd_vld_d = rd_vld_q;
    if (cmd_i.add_wr) begin
      fill_d = fill_q + ual_pkg::CNT_W'(1);
    end else if (cmd_i.move_wr) begin
      fill_d = fill_q - ual_pkg::CNT_W'(1);
    end else if (cmd_i.clear) begin
      fill_d = '0;
    end
    if (cmd_i.scan_start) begin
      scan_d   = '0;
      rd_vld_d = 1'b0;
    end else if (cmd_i.scan_step) begin
      rd_vld_d = scan_more;
      if (scan_more) begin
        scan_d = scan_q + ual_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      scan_q   <= scan_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // captured item and result of the running command
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q          <= ual_pkg::op_e'(in_command_i);
      val_q         <= in_value_i;
      res_status_q  <= ual_pkg::ST_OK;
      res_idx_q     <= '0;
      res_removed_q <= '0;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.add_wr) begin
        res_idx_q <= fill_q[ual_pkg::IDX_W-1:0];
      end
      if (cmd_i.scan_step && hit) begin
        res_idx_q <= rd_idx_q;
        if (op_q == ual_pkg::OP_DELETE) begin
          res_removed_q <= val_q;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q  <= res_status_q;
      out_index_q   <= ual_pkg::FOUND_W'(res_idx_q);
      out_removed_q <= res_removed_q;
      out_count_q   <= ual_pkg::COUNT_W'(fill_q);
    end
  end

  assign out_status_o  = out_status_q;
  assign out_index_o   = out_index_q;
  assign out_removed_o = out_removed_q;
  assign out_count_o   = out_count_q;
  assign fill_o        = fill_q;

endmodule

// File: design/unsorted_array_list.sv
// unsorted array list: add, clear and a delete of an empty list pass through idle, exec
// and result; a search, or a delete of a non-empty list, adds a scan state before the
// result, and a delete hit adds the move read and move write states after the scan. a
// new transfer is taken only once the result is loaded, so one item is in work at a time.
// the scan reads one entry a cycle from the entry memory read port. reset empties the
// list and sets the capacity register to 16; entry memory is not cleared.
module unsorted_array_list (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ual_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [31:0] item_value
  input  logic [1:0]                          s_axis_tuser,   // [1:0] command
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [3:0] found_index, [35:4] removed_value, [40:36] entry_count, rest zero
  output logic [ual_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,   // [1:0] status
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ual_pkg::APB_AW-1:0]          paddr,
  input  logic [ual_pkg::APB_DW-1:0]          pwdata,
  output logic [ual_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  logic [ual_pkg::CAP_W-1:0]   cap_q;
  ual_pkg::ctrl_cmd_t          cmd;
  ual_pkg::dp_stat_t           stat;
  ual_pkg::status_e            out_status;
  logic [ual_pkg::FOUND_W-1:0] out_index;
  logic [ual_pkg::VAL_W-1:0]   out_removed;
  logic [ual_pkg::COUNT_W-1:0] out_count;
  logic [ual_pkg::CNT_W-1:0]   fill;
  logic                        cap_sel;

  // capacity register
  assign pready  = 1'b1;
  assign cap_sel = paddr[ual_pkg::APB_AW-1:2] == ual_pkg::REG_CAPACITY;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= ual_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_q <= pwdata[ual_pkg::CAP_W-1:0];
    end
  end

  assign prdata = cap_sel ? ual_pkg::APB_DW'(cap_q) : '0;

  ual_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ual_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cap_i         (cap_q),
    .in_command_i  (s_axis_tuser),
    .in_value_i    (s_axis_tdata[ual_pkg::VAL_W-1:0]),
    .out_status_o  (out_status),
    .out_index_o   (out_index),
    .out_removed_o (out_removed),
    .out_count_o   (out_count),
    .fill_o        (fill)
  );

  // result packing
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {7'd0, out_count, out_removed, out_index};

`ifndef NO_ASSERTIONS
  // one item at a time: the input side closes right after a transfer
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // the fill count stays within the storage
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ual_pkg::CMP_W'(fill) <= ual_pkg::CMP_W'(ual_pkg::CAPACITY))
    else $error("fill count beyond capacity");

  // an empty report comes with an empty list and no index
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ual_pkg::ST_EMPTY))
      |-> (m_axis_tdata[40:36] == '0 && m_axis_tdata[3:0] == '0))
    else $error("empty status with entries or index");
`endif

endmodule

// File: sim/tb_top.sv
// testbench for the unsorted array list: command stream in, checked result stream out
module tb_top;
  import ual_pkg::*;

  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 80;
  localparam logic [APB_AW-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  // one expected answer of the list
  typedef struct {
    status_e            status;
    logic [FOUND_W-1:0] idx;
    logic [VAL_W-1:0]   removed;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  // list predictor and queue of pending answers
  class list_scoreboard;
    logic [VAL_W-1:0] entries [CAPACITY];
    int unsigned      fill;
    int unsigned      cap_reg;
    int               errors;
    list_result_t     answer_q [$];

    function new();
      fill    = 0;
      cap_reg = CAP_RESET;
      errors  = 0;
    endfunction

    function int pending();
      return answer_q.size();
    endfunction

    // first entry below the fill that equals the value
    function bit find_first(logic [VAL_W-1:0] v, output int unsigned k);
      k = 0;
      for (int i = 0; i < fill; i++) begin
        if (entries[i] == v) begin
          k = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // apply one accepted command and queue its answer
    function void note_command(op_e op, logic [VAL_W-1:0] v);
      list_result_t r;
      int unsigned  lim;
      int unsigned  k;
      lim = (cap_reg > CAPACITY) ? CAPACITY : cap_reg;
      r.status  = ST_OK;
      r.idx     = '0;
      r.removed = '0;
      case (op)
        OP_ADD: begin
          if (fill >= lim) begin
            r.status = ST_FULL;
          end else begin
            r.idx         = FOUND_W'(fill);
            entries[fill] = v;
            fill++;
          end
        end
        OP_DELETE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (!find_first(v, k)) begin
            r.status = ST_NOT_FOUND;
          end else begin
            // last entry moves into the hole
            r.idx     = FOUND_W'(k);
            r.removed = entries[k];
            fill--;
            entries[k] = entries[fill];
          end
        end
        OP_SEARCH: begin
          if (find_first(v, k)) r.idx = FOUND_W'(k);
          else r.status = ST_NOT_FOUND;
        end
        default: begin
          fill = 0;
        end
      endcase
      r.count = COUNT_W'(fill);
      answer_q.push_back(r);
    endfunction

    // compare one result transfer with the oldest answer
    function void check_result(status_e st, logic [FOUND_W-1:0] idx,
                               logic [VAL_W-1:0] rem, logic [COUNT_W-1:0] cnt);
      list_result_t e;
      if (answer_q.size() == 0) begin
        $error("result transfer with no command pending, status %0d", st);
        errors++;
        return;
      end
      e = answer_q.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (idx !== e.idx) begin
        $error("found_index: expected %0d, actual %0d", e.idx, idx);
        errors++;
      end
      if (rem !== e.removed) begin
        $error("removed_value: expected %0d, actual %0d",
               $signed(e.removed), $signed(rem));
        errors++;
      end
      if (cnt !== e.count) begin
        $error("entry_count: expected %0d, actual %0d", e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] item_value
  logic [1:0]             s_axis_tuser  = '0;   // [1:0] command
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [3:0] found_index, [35:4] removed_value, [40:36] entry_count
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;         // [1:0] status
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [APB_AW-1:0]      paddr         = '0;
  logic [APB_DW-1:0]      pwdata        = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  list_scoreboard   sb;
  bit               quiet    = 1'b0;
  bit               hold_req = 1'b0;
  int               stall_cycles = 0;
  logic [VAL_W-1:0] value_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                       32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_002A,
                                       32'h8000_0001, 32'h7FFF_FFFE};

  unsorted_array_list u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // offer one command and hold it until the transfer
  task automatic send_cmd(op_e op, logic [VAL_W-1:0] v);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(op, v);
  endtask

  // sender gap
  task automatic idle_src(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // pause the sender until every answer has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // capacity register write, then read back
  task automatic set_capacity(logic [CAP_W-1:0] c);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {(APB_DW - CAP_W)'($urandom_range(0, (1 << (APB_DW - CAP_W)) - 1)), c};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.cap_reg = c;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CAP_W-1:0] !== c) begin
      $error("active_capacity: expected %0d, actual %0d", c, prdata[CAP_W-1:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result receiver with random and long hold-offs
  initial begin : result_sink
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(status_e'(m_axis_tuser), m_axis_tdata[3:0],
                      m_axis_tdata[35:4], m_axis_tdata[40:36]);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [VAL_W-1:0] v;
    op_e              op;
    int unsigned      pick;
    int               caps [8];
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, extremes, duplicates, swap with last, clear
    send_cmd(OP_SEARCH, 32'h0000_0000);
    send_cmd(OP_DELETE, 32'h0000_0005);
    send_cmd(OP_ADD,    32'h8000_0000);
    send_cmd(OP_ADD,    32'h7FFF_FFFF);
    send_cmd(OP_ADD,    32'h0000_0000);
    send_cmd(OP_ADD,    32'hFFFF_FFFF);
    send_cmd(OP_ADD,    32'h7FFF_FFFF);
    send_cmd(OP_SEARCH, 32'h7FFF_FFFF);
    send_cmd(OP_SEARCH, 32'h1234_5678);
    send_cmd(OP_DELETE, 32'h8000_0000);
    send_cmd(OP_SEARCH, 32'h7FFF_FFFF);
    send_cmd(OP_DELETE, 32'h5555_5555);
    send_cmd(OP_DELETE, 32'hFFFF_FFFF);
    send_cmd(OP_CLEAR,  32'hAAAA_AAAA);
    send_cmd(OP_SEARCH, 32'h0000_0000);
    wait_drained();

    // small capacity reaches full
    set_capacity(5'd2);
    send_cmd(OP_ADD, 32'h0000_0011);
    send_cmd(OP_ADD, 32'h0000_0022);
    send_cmd(OP_ADD, 32'h0000_0033);
    wait_drained();

    // capacity lowered below the fill keeps the entries
    set_capacity(5'd1);
    send_cmd(OP_ADD,    32'h0000_0044);
    send_cmd(OP_SEARCH, 32'h0000_0022);
    wait_drained();

    // zero capacity, then empty the list by deletes
    set_capacity(5'd0);
    send_cmd(OP_ADD,    32'h0000_0055);
    send_cmd(OP_DELETE, 32'h0000_0011);
    send_cmd(OP_DELETE, 32'h0000_0022);
    send_cmd(OP_DELETE, 32'h0000_0011);
    wait_drained();

    // random phases over several capacities
    caps = '{16, 31, 3, 1, 0, 17, 16, 16};
    caps[6] = $urandom_range(2, 15);
    foreach (caps[p]) begin
      quiet = (p == 5) || (p == 7);
      set_capacity(CAP_W'(caps[p]));
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        op = (pick < 45) ? OP_ADD : (pick < 70) ? OP_DELETE :
             (pick < 92) ? OP_SEARCH : OP_CLEAR;
        // mostly values that hit stored entries or corner values
        pick = $urandom_range(0, 3);
        if (pick >= 2 && sb.fill > 0) v = sb.entries[$urandom_range(0, sb.fill - 1)];
        else if (pick == 1) v = value_pool[$urandom_range(0, 7)];
        else v = $urandom;
        if (!quiet && $urandom_range(0, 5) == 0) idle_src($urandom_range(1, 6));
        send_cmd(op, v);
      end
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
